// File: rtl/ffha_pkg.sv
// Shared types, constants and helpers of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int MAX_RECORDS = 256;
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [31:0] LARGE_REQ     = 32'h0010_0000;
  localparam logic [31:0] MIN_ALIGN     = 32'd4;
  localparam logic [31:0] HEAP_BASE_RST = 32'd0;
  localparam logic [31:0] HEAP_SIZE_RST = 32'd50331648;

  // Operation codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // Register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP,
    S_FF_RD, S_FF_LD, S_FF_CHK, S_FF_AP1, S_FF_AP2,
    S_LG_RD, S_LG_LD, S_LG_CHK,
    S_BK_RD, S_BK_LD, S_BK_END,
    S_OV_RD, S_OV_LD, S_LG_FIN,
    S_BP_CALC, S_BP_CHK,
    S_FR_RD, S_FR_LD,
    S_MG_RD, S_MG_LD, S_MJ_RD, S_MJ_LD,
    S_DROP, S_DROP_CP,
    S_DONE
  } state_t;

  // One entry of the record table
  typedef struct packed {
    logic [31:0] st;
    logic [31:0] len;
    logic        fr;
  } rec_t;

  typedef struct packed {
    logic        func;
    logic [31:0] req_size;
    logic [31:0] alignment;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    status_t     status;
  } rsp_t;

  // (x + m) & ~m with m = alignment - 1
  function automatic logic [31:0] round_up(input logic [31:0] x, input logic [31:0] m);
    return (x + m) & ~m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/first_fit_heap_allocator_unit.sv
// Top level: register port, request/response handshake and record table.
`default_nettype none
// Heap allocator with a first-fit free list and a bump pointer. One request
// is served at a time: in_ready is high only while the sequencer is idle.
// Every step reads one record from the table RAM (one read port, registered
// read), so costs scale with the record count n: an allocate walks the
// records by first fit; if none fits, a request of 1 MiB or more tries the
// large path, which scans the table for a blocker per free candidate and
// makes an overlap pass when a candidate fits, else the bump pointer serves
// it; a free searches the table for the block, then repeats a merge pass
// once per merge. The result sits in an output register, so the next
// request is taken while it waits. No clearing pass follows reset: only
// records below the fill count are read.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        func,
  input  wire logic [31:0] req_size,
  input  wire logic [31:0] alignment,
  input  wire logic [31:0] free_address,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] block_address,
  output      logic [1:0]  status
);

  logic [31:0] heap_base, heap_size;
  logic        wr;
  logic        rsp_valid, rsp_take;
  rsp_t        rsp;
  req_t        req;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  rec_t             ram_wdata, ram_rdata;

  // Register port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SIZE) ? heap_size : heap_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RST;
      heap_size <= HEAP_SIZE_RST;
    end else if (wr) begin
      if (paddr[2] == REG_BASE) begin
        heap_base <= pwdata;
      end else begin
        heap_size <= pwdata;
      end
    end
  end

  // Output register
  assign rsp_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_valid && rsp_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (rsp_valid && rsp_take) begin
      block_address <= rsp.block_address;
      status        <= rsp.status;
    end
  end

  assign req = '{func: func, req_size: req_size, alignment: alignment,
                 free_address: free_address};

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .req       (req),
    .ready     (in_ready),
    .rsp_valid (rsp_valid),
    .rsp_take  (rsp_take),
    .rsp       (rsp),
    .heap_base (heap_base),
    .heap_size (heap_size),
    .base_wr   (wr && paddr[2] == REG_BASE),
    .base_val  (pwdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ffha_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_RECORDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ffha_ctrl.sv
// Sequencer and datapath that walk the record table for alloc and free.
`default_nettype none
module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire req_t             req,
  output      logic             ready,
  output      logic             rsp_valid,
  input  wire logic             rsp_take,
  output      rsp_t             rsp,
  input  wire logic [31:0]      heap_base,
  input  wire logic [31:0]      heap_size,
  input  wire logic             base_wr,
  input  wire logic [31:0]      base_val,
  output      logic             ram_we,
  output      logic [IDX_W-1:0] ram_waddr,
  output      rec_t             ram_wdata,
  output      logic [IDX_W-1:0] ram_raddr,
  input  wire rec_t             ram_rdata
);

  state_t state, state_next;
  logic [CNT_W-1:0] used, used_next, ci, ci_next, cj, cj_next;
  logic [31:0] bump, bump_next;
  logic        op_func, op_func_next;
  logic [31:0] op_size, op_size_next, op_amask, op_amask_next;
  logic [31:0] op_faddr, op_faddr_next, heap_end, heap_end_next;
  logic [31:0] r_st, r_st_next, r_len, r_len_next, r_en, r_en_next;
  logic [31:0] r_al, r_al_next, r_aend, r_aend_next;
  logic        r_fr, r_fr_next;
  logic [31:0] blocker, blocker_next;
  rsp_t        res, res_next;

  logic [31:0] align_eff;
  logic        room;
  logic        x_live;

  assign align_eff = (req.alignment < MIN_ALIGN) ? MIN_ALIGN : req.alignment;
  assign room      = (used < CNT_W'(MAX_RECORDS));
  assign x_live    = ram_rdata.fr && (ram_rdata.len != 32'd0);

  assign ready     = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign rsp       = res;

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      bump  <= HEAP_BASE_RST;
    end else begin
      state <= state_next;
      used  <= used_next;
      bump  <= bump_next;
    end
    ci       <= ci_next;
    cj       <= cj_next;
    op_func  <= op_func_next;
    op_size  <= op_size_next;
    op_amask <= op_amask_next;
    op_faddr <= op_faddr_next;
    heap_end <= heap_end_next;
    r_st     <= r_st_next;
    r_len    <= r_len_next;
    r_en     <= r_en_next;
    r_al     <= r_al_next;
    r_aend   <= r_aend_next;
    r_fr     <= r_fr_next;
    blocker  <= blocker_next;
    res      <= res_next;
  end

  // Next state, datapath and table port
  always_comb begin
    state_next    = state;
    used_next     = used;
    bump_next     = bump;
    ci_next       = ci;
    cj_next       = cj;
    op_func_next  = op_func;
    op_size_next  = op_size;
    op_amask_next = op_amask;
    op_faddr_next = op_faddr;
    heap_end_next = heap_end;
    r_st_next     = r_st;
    r_len_next    = r_len;
    r_en_next     = r_en;
    r_al_next     = r_al;
    r_aend_next   = r_aend;
    r_fr_next     = r_fr;
    blocker_next  = blocker;
    res_next      = res;
    ram_we        = 1'b0;
    ram_waddr     = ci[IDX_W-1:0];
    ram_wdata     = '0;
    ram_raddr     = ci[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (base_wr && used == '0) begin
          bump_next = base_val;
        end
        if (start) begin
          op_func_next  = req.func;
          op_amask_next = align_eff - 32'd1;
          op_size_next  = (req.req_size == 32'd0) ? align_eff : req.req_size;
          op_faddr_next = req.free_address;
          state_next    = S_PREP;
        end
      end

      S_PREP: begin
        heap_end_next = heap_base + heap_size;
        ci_next       = '0;
        res_next      = '{block_address: 32'd0, status: ST_OK};
        state_next    = (op_func == FN_FREE) ? S_FR_RD : S_FF_RD;
      end

      // First fit over free records
      S_FF_RD: begin
        if (ci >= used) begin
          ci_next    = '0;
          state_next = (op_size >= LARGE_REQ) ? S_LG_RD : S_BP_CALC;
        end else begin
          state_next = S_FF_LD;
        end
      end
      S_FF_LD: begin
        r_st_next  = ram_rdata.st;
        r_len_next = ram_rdata.len;
        r_fr_next  = ram_rdata.fr;
        r_en_next  = ram_rdata.st + ram_rdata.len;
        r_al_next  = round_up(ram_rdata.st, op_amask);
        state_next = S_FF_CHK;
      end
      S_FF_CHK: begin
        if (r_fr && r_len != 32'd0 && r_al >= r_st && r_al <= r_en &&
            op_size <= r_en - r_al) begin
          ram_we     = 1'b1;
          ram_wdata  = '{st: r_al, len: op_size, fr: 1'b0};
          res_next.block_address = r_al;
          state_next = S_FF_AP1;
        end else begin
          ci_next    = ci + 1'b1;
          state_next = S_FF_RD;
        end
      end
      S_FF_AP1: begin
        r_aend_next = r_al + op_size;
        if (r_al > r_st && room) begin
          ram_we    = 1'b1;
          ram_waddr = used[IDX_W-1:0];
          ram_wdata = '{st: r_st, len: r_al - r_st, fr: 1'b1};
          used_next = used + 1'b1;
        end
        state_next = S_FF_AP2;
      end
      S_FF_AP2: begin
        if (r_aend < r_en && room) begin
          ram_we    = 1'b1;
          ram_waddr = used[IDX_W-1:0];
          ram_wdata = '{st: r_aend, len: r_en - r_aend, fr: 1'b1};
          used_next = used + 1'b1;
        end
        state_next = S_DONE;
      end

      // Large request: claim free space up to the next allocated block
      S_LG_RD: begin
        state_next = (ci >= used) ? S_BP_CALC : S_LG_LD;
      end
      S_LG_LD: begin
        r_st_next  = ram_rdata.st;
        r_len_next = ram_rdata.len;
        r_fr_next  = ram_rdata.fr;
        r_al_next  = round_up(ram_rdata.st, op_amask);
        state_next = S_LG_CHK;
      end
      S_LG_CHK: begin
        if (!r_fr || r_len == 32'd0 || r_al < r_st || op_size > heap_end - r_al) begin
          ci_next    = ci + 1'b1;
          state_next = S_LG_RD;
        end else begin
          r_en_next    = r_al + op_size;
          blocker_next = heap_end;
          cj_next      = '0;
          state_next   = S_BK_RD;
        end
      end
      S_BK_RD: begin
        ram_raddr  = cj[IDX_W-1:0];
        state_next = (cj >= used) ? S_BK_END : S_BK_LD;
      end
      S_BK_LD: begin
        if (!ram_rdata.fr && ram_rdata.len != 32'd0 && ram_rdata.st >= r_al &&
            ram_rdata.st < blocker) begin
          blocker_next = ram_rdata.st;
        end
        cj_next    = cj + 1'b1;
        state_next = S_BK_RD;
      end
      S_BK_END: begin
        if (r_en > blocker) begin
          ci_next    = ci + 1'b1;
          state_next = S_LG_RD;
        end else begin
          cj_next    = '0;
          state_next = S_OV_RD;
        end
      end
      S_OV_RD: begin
        ram_raddr  = cj[IDX_W-1:0];
        state_next = (cj >= used) ? S_LG_FIN : S_OV_LD;
      end
      S_OV_LD: begin
        // kill free records that the claimed block overlaps
        if (x_live && ram_rdata.st < r_en && r_al < ram_rdata.st + ram_rdata.len) begin
          ram_we    = 1'b1;
          ram_waddr = cj[IDX_W-1:0];
          ram_wdata = '{st: ram_rdata.st, len: 32'd0, fr: 1'b0};
        end
        cj_next    = cj + 1'b1;
        state_next = S_OV_RD;
      end
      S_LG_FIN: begin
        if (room) begin
          ram_we    = 1'b1;
          ram_waddr = used[IDX_W-1:0];
          ram_wdata = '{st: r_al, len: op_size, fr: 1'b0};
          used_next = used + 1'b1;
        end
        if (r_en > bump) begin
          bump_next = r_en;
        end
        res_next.block_address = r_al;
        state_next = S_DONE;
      end

      // Bump pointer
      S_BP_CALC: begin
        r_al_next  = round_up(bump, op_amask);
        state_next = S_BP_CHK;
      end
      S_BP_CHK: begin
        if (op_size > heap_end - r_al) begin
          res_next = '{block_address: 32'd0, status: ST_OOM};
        end else begin
          bump_next = r_al + op_size;
          res_next.block_address = r_al;
          if (room) begin
            ram_we    = 1'b1;
            ram_waddr = used[IDX_W-1:0];
            ram_wdata = '{st: r_al, len: op_size, fr: 1'b0};
            used_next = used + 1'b1;
          end
        end
        state_next = S_DONE;
      end

      // Free: find the record, then merge
      S_FR_RD: begin
        if (ci >= used) begin
          res_next.status = ST_NOTFOUND;
          state_next      = S_DONE;
        end else begin
          state_next = S_FR_LD;
        end
      end
      S_FR_LD: begin
        if (ram_rdata.len != 32'd0 && ram_rdata.st == op_faddr) begin
          ram_we     = 1'b1;
          ram_wdata  = '{st: ram_rdata.st, len: ram_rdata.len, fr: 1'b1};
          ci_next    = '0;
          state_next = S_MG_RD;
        end else begin
          ci_next    = ci + 1'b1;
          state_next = S_FR_RD;
        end
      end
      S_MG_RD: begin
        state_next = (ci >= used) ? S_DONE : S_MG_LD;
      end
      S_MG_LD: begin
        r_st_next  = ram_rdata.st;
        r_len_next = ram_rdata.len;
        r_en_next  = ram_rdata.st + ram_rdata.len;
        if (x_live) begin
          cj_next    = ci + 1'b1;
          state_next = S_MJ_RD;
        end else begin
          ci_next    = ci + 1'b1;
          state_next = S_MG_RD;
        end
      end
      S_MJ_RD: begin
        ram_raddr = cj[IDX_W-1:0];
        if (cj >= used) begin
          ci_next    = ci + 1'b1;
          state_next = S_MG_RD;
        end else begin
          state_next = S_MJ_LD;
        end
      end
      S_MJ_LD: begin
        if (x_live && r_en == ram_rdata.st) begin
          ram_we     = 1'b1;
          ram_wdata  = '{st: r_st, len: r_len + ram_rdata.len, fr: 1'b1};
          state_next = S_DROP;
        end else if (x_live && ram_rdata.st + ram_rdata.len == r_st) begin
          ram_we     = 1'b1;
          ram_wdata  = '{st: ram_rdata.st, len: r_len + ram_rdata.len, fr: 1'b1};
          state_next = S_DROP;
        end else begin
          cj_next    = cj + 1'b1;
          state_next = S_MJ_RD;
        end
      end
      S_DROP: begin
        // move the last record into the hole, then restart the pass
        used_next = used - 1'b1;
        ram_raddr = used_next[IDX_W-1:0];
        if (cj != used_next) begin
          state_next = S_DROP_CP;
        end else begin
          ci_next    = '0;
          state_next = S_MG_RD;
        end
      end
      S_DROP_CP: begin
        ram_we     = 1'b1;
        ram_waddr  = cj[IDX_W-1:0];
        ram_wdata  = ram_rdata;
        ci_next    = '0;
        state_next = S_MG_RD;
      end

      S_DONE: begin
        if (rsp_take) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond table depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_we)
    else $error("table written outside a request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.status != ST_OK) |-> res.block_address == 32'd0)
    else $error("failed request returns nonzero address");

  a_copy_after_drop: assert property (@(posedge clk) disable iff (rst)
    state == S_DROP_CP |-> $past(state) == S_DROP)
    else $error("record copy without drop");

endmodule
`default_nettype wire

// File: tb/tb_first_fit_heap_allocator_unit.sv
// Testbench for the first-fit heap allocator: directed table plus random traffic, self-checked.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_unit;
  import ffha_pkg::*;

  localparam int          CYCLE_LIMIT = 30_000_000;
  localparam logic [2:0]  ADDR_BASE   = 3'd0;
  localparam logic [2:0]  ADDR_SIZE   = 3'd4;

  typedef struct {
    logic [31:0] addr;
    status_t     st;
  } reply_t;

  typedef struct {
    logic        f;
    logic [31:0] sz;
    logic [31:0] al;
    logic [31:0] fa;
    bit          use_last;  // free the address of the previous allocation
    bit          typed;     // expected reply given in the row
    logic [31:0] t_addr;
    status_t     t_st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FN_ALLOC;
  logic [31:0] req_size = '0, alignment = '0, free_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] block_address;
  logic [1:0]  status;

  first_fit_heap_allocator_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the allocator state
  logic [31:0] rec_st [MAX_RECORDS];
  logic [31:0] rec_len[MAX_RECORDS];
  bit          rec_fr [MAX_RECORDS];
  int          rec_cnt;
  logic [31:0] bump_ptr;
  logic [31:0] heap_base_r = HEAP_BASE_RST;
  logic [31:0] heap_size_r = HEAP_SIZE_RST;

  reply_t      pending_replies[$];
  logic [31:0] live_blocks[$];
  logic [31:0] last_addr;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  bit          quiet = 1'b0;
  bit          held = 1'b0;
  int          hold_left = 0;

  function automatic logic [31:0] align_up(logic [31:0] x, logic [31:0] a);
    return (x + a - 32'd1) & ~(a - 32'd1);
  endfunction

  function automatic bit is_free_live(int k);
    return rec_fr[k] && rec_len[k] != 0;
  endfunction

  function automatic void rec_add(logic [31:0] st, logic [31:0] len, bit fr);
    if (len == 0 || rec_cnt >= MAX_RECORDS) return;
    rec_st[rec_cnt] = st;
    rec_len[rec_cnt] = len;
    rec_fr[rec_cnt] = fr;
    rec_cnt++;
  endfunction

  function automatic void rec_del(int k);
    rec_cnt--;
    if (k != rec_cnt) begin
      rec_st[k] = rec_st[rec_cnt];
      rec_len[k] = rec_len[rec_cnt];
      rec_fr[k] = rec_fr[rec_cnt];
    end
  endfunction

  // Merge touching free records until nothing changes
  function automatic void coalesce();
    bit merged;
    do begin
      merged = 1'b0;
      for (int i = 0; i < rec_cnt && !merged; i++) begin
        if (!is_free_live(i)) continue;
        for (int j = i + 1; j < rec_cnt; j++) begin
          if (!is_free_live(j)) continue;
          if (rec_st[i] + rec_len[i] == rec_st[j]) begin
            rec_len[i] += rec_len[j];
            rec_del(j);
            merged = 1'b1;
            break;
          end
          if (rec_st[j] + rec_len[j] == rec_st[i]) begin
            rec_st[i] = rec_st[j];
            rec_len[i] += rec_len[j];
            rec_del(j);
            merged = 1'b1;
            break;
          end
        end
      end
    end while (merged);
  endfunction

  function automatic logic [31:0] heap_alloc(logic [31:0] sz, logic [31:0] al,
                                             output status_t st);
    logic [31:0] hend, s, e, a, aend, blk, res;
    hend = heap_base_r + heap_size_r;
    if (al < MIN_ALIGN) al = MIN_ALIGN;
    if (sz == 0) sz = al;
    st = ST_OK;
    // first fit with split
    for (int i = 0; i < rec_cnt; i++) begin
      if (!is_free_live(i)) continue;
      s = rec_st[i];
      e = s + rec_len[i];
      a = align_up(s, al);
      if (a >= s && a <= e && sz <= e - a) begin
        aend = a + sz;
        rec_st[i] = a;
        rec_len[i] = sz;
        rec_fr[i] = 1'b0;
        if (a > s) rec_add(s, a - s, 1'b1);
        if (aend < e) rec_add(aend, e - aend, 1'b1);
        return a;
      end
    end
    // large request: claim free space up to the next used block
    if (sz >= LARGE_REQ) begin
      for (int i = 0; i < rec_cnt; i++) begin
        if (!is_free_live(i)) continue;
        a = align_up(rec_st[i], al);
        if (a < rec_st[i] || sz > hend - a) continue;
        e = a + sz;
        blk = hend;
        for (int j = 0; j < rec_cnt; j++)
          if (!rec_fr[j] && rec_len[j] != 0 && rec_st[j] >= a && rec_st[j] < blk)
            blk = rec_st[j];
        if (e > blk) continue;
        for (int j = 0; j < rec_cnt; j++)
          if (is_free_live(j) && a < rec_st[j] + rec_len[j] && rec_st[j] < a + sz) begin
            rec_fr[j] = 1'b0;
            rec_len[j] = 0;
          end
        rec_add(a, sz, 1'b0);
        if (e > bump_ptr) bump_ptr = e;
        return a;
      end
    end
    // bump
    res = align_up(bump_ptr, al);
    if (sz > hend - res) begin
      st = ST_OOM;
      return 32'd0;
    end
    bump_ptr = res + sz;
    rec_add(res, sz, 1'b0);
    return res;
  endfunction

  function automatic status_t heap_release(logic [31:0] addr);
    for (int i = 0; i < rec_cnt; i++)
      if (rec_len[i] != 0 && rec_st[i] == addr) begin
        rec_fr[i] = 1'b1;
        coalesce();
        return ST_OK;
      end
    return ST_NOTFOUND;
  endfunction

  // Register write: setup then access
  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_BASE) begin
      heap_base_r = d;
      if (rec_cnt == 0) bump_ptr = d;
    end else begin
      heap_size_r = d;
    end
  endtask

  // Wait until every reply is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_req(logic f, logic [31:0] sz, logic [31:0] al, logic [31:0] fa,
                          bit typed, logic [31:0] t_addr, status_t t_st);
    reply_t r;
    if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f; req_size <= sz; alignment <= al; free_address <= fa;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent <= beats_sent + 1;
    if (f == FN_ALLOC) begin
      r.addr = heap_alloc(sz, al, r.st);
    end else begin
      r.addr = 32'd0;
      r.st = heap_release(fa);
    end
    last_addr = r.addr;
    if (typed) begin
      r.addr = t_addr;
      r.st = t_st;
    end
    pending_replies.push_back(r);
  endtask

  function automatic logic [31:0] pick_align();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return $urandom_range(1, 4);
      default: return 32'd1 << $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 19))
      0, 1: return 32'd0;
      2, 3, 4: return $urandom_range(32'h10_0000, 32'h28_0000);
      5, 6: return $urandom_range(513, 32'h1_0000);
      7: return $urandom;
      default: return $urandom_range(1, 512);
    endcase
  endfunction

  // Random traffic: free_pct percent frees, mostly of live blocks, some junk addresses
  task automatic random_traffic(int n, int free_pct);
    int k;
    logic [31:0] a;
    status_t s;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_on <= ($urandom_range(0, 3) != 0);
      if (live_blocks.size() != 0 && $urandom_range(0, 99) < free_pct) begin
        if ($urandom_range(0, 9) != 0) begin
          k = $urandom_range(0, live_blocks.size() - 1);
          a = live_blocks[k];
          live_blocks.delete(k);
        end else begin
          a = $urandom;
        end
        send_req(FN_FREE, $urandom, $urandom, a, 1'b0, '0, ST_OK);
      end else begin
        send_req(FN_ALLOC, pick_size(), pick_align(), $urandom, 1'b0, '0, ST_OK);
        if (pending_replies.size() != 0 && pending_replies[$].st == ST_OK)
          live_blocks.push_back(last_addr);
      end
    end
  endtask

  // Directed rows, on the reset heap (base 0)
  row_t rows[] = '{
    '{FN_ALLOC, 32'd0,          32'd0,          32'd0, 0, 1, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'd1,          32'd1,          32'd0, 0, 1, 32'd4,  ST_OK},
    '{FN_ALLOC, 32'd100,        32'd16,         32'd0, 0, 1, 32'd16, ST_OK},
    '{FN_FREE,  32'd0,          32'd0,  32'hDEAD_BEEF, 0, 1, 32'd0,  ST_NOTFOUND},
    '{FN_ALLOC, 32'hFFFF_FFFF,  32'h8000_0000,  32'd0, 0, 1, 32'd0,  ST_OOM},
    '{FN_FREE,  32'd0,          32'd0,          32'd4, 0, 1, 32'd0,  ST_OK},
    '{FN_FREE,  32'd0,          32'd0,          32'd4, 0, 1, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'd1,          32'd1,          32'd0, 0, 0, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'h10_0000,    32'h1000,       32'd0, 0, 0, 32'd0,  ST_OK},
    '{FN_FREE,  32'd0,          32'd0,          32'd0, 1, 0, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'h20_0000,    32'h1000,       32'd0, 0, 0, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'd12,         32'd3,          32'd0, 0, 0, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'd0,          32'h8000_0000,  32'd0, 0, 0, 32'd0,  ST_OK},
    '{FN_FREE,  32'd0,          32'd0,          32'd0, 0, 1, 32'd0,  ST_OK},
    '{FN_FREE,  32'hFFFF_FFFF,  32'hFFFF_FFFF, 32'd16, 0, 0, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'h1000,       32'd4,          32'd0, 0, 0, 32'd0,  ST_OK},
    '{FN_FREE,  32'd0,          32'd0,          32'd0, 1, 0, 32'd0,  ST_OK},
    '{FN_ALLOC, 32'h30_0000,    32'd0,          32'd0, 0, 0, 32'd0,  ST_OK}
  };

  initial begin
    rec_cnt = 0;
    bump_ptr = HEAP_BASE_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // base write with an empty table also moves the bump pointer
    reg_write(ADDR_BASE, 32'h40);
    reg_write(ADDR_BASE, 32'h0);
    reg_write(ADDR_SIZE, HEAP_SIZE_RST);

    foreach (rows[i])
      send_req(rows[i].f, rows[i].sz, rows[i].al,
               rows[i].use_last ? last_addr : rows[i].fa,
               rows[i].typed, rows[i].t_addr, rows[i].t_st);
    drain();

    // small heap: out of memory is common
    reg_write(ADDR_BASE, 32'h1000);
    reg_write(ADDR_SIZE, 32'h1_0000);
    random_traffic(220, 45);
    drain();

    // heap at the top of the address space, size wrapping around
    reg_write(ADDR_BASE, 32'hFFFF_FFFC);
    reg_write(ADDR_SIZE, 32'hFFFF_FFFF);
    random_traffic(180, 45);
    drain();

    // fill the record table, no idling during the fill loop
    reg_write(ADDR_BASE, 32'h0);
    reg_write(ADDR_SIZE, 32'h0);
    random_traffic(10, 0);
    drain();
    reg_write(ADDR_SIZE, HEAP_SIZE_RST);
    quiet <= 1'b1;
    for (int i = 0; i < 280; i++) begin
      if (i % 60 == 59 && live_blocks.size() != 0)
        send_req(FN_FREE, '0, '0, live_blocks.pop_front(), 1'b0, '0, ST_OK);
      else
        send_req(FN_ALLOC, $urandom_range(1, 64), 32'd1 << $urandom_range(0, 4), '0,
                 1'b0, '0, ST_OK);
    end
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls plus one long hold to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held && beats_sent >= 60) begin
      held <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result beat against the oldest expected reply
  always @(posedge clk) begin : check_replies
    reply_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: addr %h status %0d", block_address, status);
      end else begin
        e = pending_replies.pop_front();
        if (block_address !== e.addr || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: exp addr %h status %0d, got addr %h status %0d",
                     e.addr, e.st, block_address, status);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_unit.sv
tb/tb_first_fit_heap_allocator_unit.sv
